/* rtl/core/supersample_outline_colorizer_defines.svh */
// Assertion macros shared by the colorizer RTL.
`ifndef SUPERSAMPLE_OUTLINE_COLORIZER_DEFINES_SVH
`define SUPERSAMPLE_OUTLINE_COLORIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSOC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSOC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ssoc_pkg.sv */
// Shared types and constants of the supersample outline colorizer.
package ssoc_pkg;

  localparam int LEVEL_W           = 8;
  localparam int IN_DATA_W         = 3 * LEVEL_W;
  localparam int FACTOR_W          = 4;
  localparam int WIDTH_W           = 9;
  localparam int COLOR_W           = 32;
  localparam int CFG_DATA_W        = 32;
  localparam int CFG_ADDR_W        = 4;
  localparam int DEF_MAX_OUT_WIDTH = 256;
  localparam int DEF_MAX_FACTOR    = 8;

  localparam logic [FACTOR_W-1:0] RST_FACTOR = 4'd1;
  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 9'd256;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 8'hff;

  typedef enum logic [1:0] {
    REG_FACTOR = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_EDGE   = 2'd2,
    REG_FILL   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [WIDTH_W-1:0]  out_width;
    logic [COLOR_W-1:0]  edge_color;
    logic [COLOR_W-1:0]  fill_color;
  } cfg_regs_t;

  // Handoff of a finished block from the accumulator to the shader.
  typedef struct packed {
    logic vld;
    logic eor;
  } blk_tag_t;

endpackage

/* rtl/core/ssoc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ssoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/ssoc_cfg.sv */
// APB register file: supersample factor, output width, edge and fill colors.
module ssoc_cfg
  import ssoc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_regs_t             cfg
);

  cfg_regs_t regs_r, regs_nxt;
  reg_idx_t  reg_idx;
  logic      wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FACTOR: regs_nxt.factor     = cfg_pwdata[FACTOR_W-1:0];
        REG_WIDTH:  regs_nxt.out_width  = cfg_pwdata[WIDTH_W-1:0];
        REG_EDGE:   regs_nxt.edge_color = cfg_pwdata[COLOR_W-1:0];
        REG_FILL:   regs_nxt.fill_color = cfg_pwdata[COLOR_W-1:0];
        default:    regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{factor: RST_FACTOR, out_width: RST_WIDTH,
                  edge_color: '0, fill_color: '0};
    end else begin
      regs_r <= regs_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FACTOR: cfg_prdata = CFG_DATA_W'(regs_r.factor);
      REG_WIDTH:  cfg_prdata = CFG_DATA_W'(regs_r.out_width);
      REG_EDGE:   cfg_prdata = CFG_DATA_W'(regs_r.edge_color);
      REG_FILL:   cfg_prdata = CFG_DATA_W'(regs_r.fill_color);
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg = regs_r;

endmodule

/* rtl/core/ssoc_accum.sv */
// Raster position counters and per-column sum memory with read-modify-write.
module ssoc_accum
  import ssoc_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
  parameter int MAX_FACTOR    = DEF_MAX_FACTOR,
  localparam int SUM_W = LEVEL_W + $clog2(MAX_FACTOR * MAX_FACTOR)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_regs_t            cfg,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  output blk_tag_t             blk_tag,
  output logic [SUM_W-1:0]     sum_bg,
  output logic [SUM_W-1:0]     sum_path,
  output logic [SUM_W-1:0]     sum_fill,
  input  logic                 blk_rdy,
  output logic                 clearing
);

  localparam int COL_W  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int SUB_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int QCMP_W = ((SUB_W > FACTOR_W) ? SUB_W : FACTOR_W) + 1;
  localparam int WCMP_W = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;
  localparam int RAM_W  = 3 * SUM_W;
  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(MAX_OUT_WIDTH - 1);
  localparam logic [QCMP_W-1:0] Q_LIMIT  = QCMP_W'(MAX_FACTOR);
  localparam logic [WCMP_W-1:0] W_LIMIT  = WCMP_W'(MAX_OUT_WIDTH);
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  // Saturating add; the first sample of a block overwrites the stale sum.
  function automatic logic [SUM_W-1:0] acc_sum(input logic [SUM_W-1:0]   base,
                                               input logic [LEVEL_W-1:0] lvl,
                                               input logic               first);
    logic [SUM_W:0] wide;
    wide = {1'b0, base} + (SUM_W + 1)'(lvl);
    if (first) begin
      acc_sum = SUM_W'(lvl);
    end else if (wide[SUM_W]) begin
      acc_sum = SUM_MAX;
    end else begin
      acc_sum = wide[SUM_W-1:0];
    end
  endfunction

  logic                accept, adv1;
  logic [SUB_W-1:0]    sub_col_r, sub_col_nxt, sub_row_r, sub_row_nxt;
  logic [SUB_W-1:0]    cur_sc, cur_sr;
  logic [COL_W-1:0]    out_col_r, out_col_nxt, cur_col;
  logic [QCMP_W-1:0]   sc_inc, sr_inc;
  logic [WCMP_W-1:0]   col_inc;
  logic                last_sub, last_row, last_col;

  logic                s1_vld_r, s1_first_r, s1_emit_r, s1_eor_r;
  logic [COL_W-1:0]    s1_col_r;
  logic [LEVEL_W-1:0]  s1_bg_r, s1_path_r, s1_fill_r;

  logic                fwd_vld_r;
  logic [COL_W-1:0]    fwd_col_r;
  logic [RAM_W-1:0]    fwd_data_r;

  logic                clr_busy_r;
  logic [COL_W-1:0]    clr_addr_r;

  logic [RAM_W-1:0]    ram_rdata, base_word, new_word, ram_wdata;
  logic [COL_W-1:0]    ram_waddr;
  logic                ram_we;

  assign adv1      = !s1_vld_r || !s1_emit_r || blk_rdy;
  assign in_tready = adv1 && !clr_busy_r;
  assign accept    = in_tvalid && in_tready;
  assign clearing  = clr_busy_r;

  // Start of image puts the marked sample at position zero.
  assign cur_sc  = in_tuser ? '0 : sub_col_r;
  assign cur_sr  = in_tuser ? '0 : sub_row_r;
  assign cur_col = in_tuser ? '0 : out_col_r;

  assign sc_inc  = QCMP_W'(cur_sc) + QCMP_W'(1);
  assign sr_inc  = QCMP_W'(cur_sr) + QCMP_W'(1);
  assign col_inc = WCMP_W'(cur_col) + WCMP_W'(1);

  // A zero register acts as one, anything above the limit as the limit.
  assign last_sub = (sc_inc >= QCMP_W'(cfg.factor)) || (sc_inc >= Q_LIMIT);
  assign last_row = (sr_inc >= QCMP_W'(cfg.factor)) || (sr_inc >= Q_LIMIT);
  assign last_col = (col_inc >= WCMP_W'(cfg.out_width)) || (col_inc >= W_LIMIT);

  always_comb begin
    sub_col_nxt = sub_col_r;
    sub_row_nxt = sub_row_r;
    out_col_nxt = out_col_r;
    if (accept) begin
      sub_row_nxt = cur_sr;
      out_col_nxt = cur_col;
      if (!last_sub) begin
        sub_col_nxt = cur_sc + SUB_W'(1);
      end else begin
        sub_col_nxt = '0;
        if (last_col) begin
          out_col_nxt = '0;
          sub_row_nxt = last_row ? '0 : cur_sr + SUB_W'(1);
        end else begin
          out_col_nxt = cur_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_col_r  <= '0;
      sub_row_r  <= '0;
      out_col_r  <= '0;
      s1_vld_r   <= 1'b0;
      fwd_vld_r  <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      sub_col_r <= sub_col_nxt;
      sub_row_r <= sub_row_nxt;
      out_col_r <= out_col_nxt;
      if (adv1) begin
        s1_vld_r  <= accept;
        fwd_vld_r <= s1_vld_r;
      end
      // Zero the sum memory once after reset, one column per cycle.
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + COL_W'(1);
        if (clr_addr_r == COL_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first_r <= (cur_sc == '0) && (cur_sr == '0);
      s1_emit_r  <= last_sub && last_row;
      s1_eor_r   <= last_col;
      s1_col_r   <= cur_col;
      s1_bg_r    <= in_tdata[0 +: LEVEL_W];
      s1_path_r  <= in_tdata[LEVEL_W +: LEVEL_W];
      s1_fill_r  <= in_tdata[2*LEVEL_W +: LEVEL_W];
    end
    // Track the write made on the edge the next sample read its column.
    if (adv1) begin
      fwd_col_r  <= s1_col_r;
      fwd_data_r <= new_word;
    end
  end

  assign base_word = (fwd_vld_r && (fwd_col_r == s1_col_r)) ? fwd_data_r : ram_rdata;

  assign new_word = {acc_sum(base_word[2*SUM_W +: SUM_W], s1_fill_r, s1_first_r),
                     acc_sum(base_word[SUM_W +: SUM_W],   s1_path_r, s1_first_r),
                     acc_sum(base_word[0 +: SUM_W],       s1_bg_r,   s1_first_r)};

  assign ram_we    = clr_busy_r || (s1_vld_r && adv1);
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_col_r;
  assign ram_wdata = clr_busy_r ? '0 : new_word;

  ssoc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (cur_col),
    .rdata (ram_rdata)
  );

  assign blk_tag.vld = s1_vld_r && s1_emit_r;
  assign blk_tag.eor = s1_eor_r;
  assign sum_bg      = new_word[0 +: SUM_W];
  assign sum_path    = new_word[SUM_W +: SUM_W];
  assign sum_fill    = new_word[2*SUM_W +: SUM_W];

endmodule

/* rtl/core/ssoc_shade.sv */
// Block average by reciprocal multiply, color blend and output register.
module ssoc_shade
  import ssoc_pkg::*;
#(
  parameter int MAX_FACTOR = DEF_MAX_FACTOR,
  localparam int SUM_W = LEVEL_W + $clog2(MAX_FACTOR * MAX_FACTOR)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_regs_t          cfg,
  input  blk_tag_t           blk_tag,
  input  logic [SUM_W-1:0]   sum_bg,
  input  logic [SUM_W-1:0]   sum_path,
  input  logic [SUM_W-1:0]   sum_fill,
  output logic               blk_rdy,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [COLOR_W-1:0] out_tdata,
  output logic               out_tlast
);

  localparam int SUB_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int QCMP_W = ((SUB_W > FACTOR_W) ? SUB_W : FACTOR_W) + 1;
  localparam int SH     = SUM_W + $clog2(MAX_FACTOR * MAX_FACTOR);
  localparam int REC_W  = SH + 1;
  localparam int PROD_W = SUM_W + REC_W;
  localparam logic [QCMP_W-1:0] Q_LIMIT = QCMP_W'(MAX_FACTOR);

  function automatic logic [LEVEL_W-1:0] avg_of(input logic [PROD_W-1:0] prod);
    logic [SUM_W-1:0] quo;
    quo = prod[SH +: SUM_W];
    if (quo > SUM_W'(LEVEL_MAX)) begin
      avg_of = LEVEL_MAX;
    end else begin
      avg_of = quo[LEVEL_W-1:0];
    end
  endfunction

  logic [REC_W-1:0] recip_tab [MAX_FACTOR];

  // ceil(2^SH / q^2): exact quotient for every sum below 2^SUM_W.
  for (genvar g = 0; g < MAX_FACTOR; g++) begin : g_recip
    localparam int D = (g + 1) * (g + 1);
    localparam int M = ((1 << SH) + D - 1) / D;
    assign recip_tab[g] = REC_W'(M);
  end

  logic [SUB_W-1:0]              q_idx;
  logic [REC_W-1:0]              recip;
  logic                          adv2, adv3, adv_out;

  logic                          s2_vld_r, s2_eor_r;
  logic [PROD_W-1:0]             prod_bg_r, prod_path_r, prod_fill_r;

  logic [LEVEL_W-1:0]            bg_avg, path_avg, fill_avg;
  logic [3:0][2*LEVEL_W-1:0]     e_prod, f_prod;
  logic [2*LEVEL_W-1:0]          a_prod;

  logic                          s3_vld_r, s3_eor_r, s3_bgnz_r;
  logic [3:0][LEVEL_W-1:0]       s3_e_r, s3_f_r;
  logic [LEVEL_W-1:0]            s3_alpha_r;

  logic [3:0][LEVEL_W-1:0]       blend;
  logic [COLOR_W-1:0]            pixel_nxt;
  logic                          out_vld_r, out_last_r;
  logic [COLOR_W-1:0]            out_data_r;

  always_comb begin
    if (cfg.factor == '0) begin
      q_idx = '0;
    end else if (QCMP_W'(cfg.factor) >= Q_LIMIT) begin
      q_idx = SUB_W'(MAX_FACTOR - 1);
    end else begin
      q_idx = SUB_W'(cfg.factor - FACTOR_W'(1));
    end
  end

  assign recip = recip_tab[q_idx];

  assign adv_out = !out_vld_r || out_tready;
  assign adv3    = !s3_vld_r || adv_out;
  assign adv2    = !s2_vld_r || adv3;
  assign blk_rdy = adv2;

  always_comb begin
    bg_avg   = avg_of(prod_bg_r);
    path_avg = avg_of(prod_path_r);
    fill_avg = avg_of(prod_fill_r);
    for (int c = 0; c < 4; c++) begin
      e_prod[c] = cfg.edge_color[LEVEL_W*c +: LEVEL_W] * path_avg;
      f_prod[c] = cfg.fill_color[LEVEL_W*c +: LEVEL_W] * fill_avg;
    end
    a_prod = (LEVEL_MAX - bg_avg) * cfg.edge_color[3*LEVEL_W +: LEVEL_W];
  end

  always_comb begin
    logic [LEVEL_W:0] ch_sum;
    for (int c = 0; c < 4; c++) begin
      ch_sum   = {1'b0, s3_e_r[c]} + {1'b0, s3_f_r[c]};
      blend[c] = ch_sum[LEVEL_W] ? LEVEL_MAX : ch_sum[LEVEL_W-1:0];
    end
    if (s3_bgnz_r) begin
      pixel_nxt = {s3_alpha_r, cfg.edge_color[3*LEVEL_W-1:0]};
    end else begin
      pixel_nxt = blend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv2) begin
        s2_vld_r <= blk_tag.vld;
      end
      if (adv3) begin
        s3_vld_r <= s2_vld_r;
      end
      if (adv_out) begin
        out_vld_r <= s3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && blk_tag.vld) begin
      s2_eor_r    <= blk_tag.eor;
      prod_bg_r   <= PROD_W'(sum_bg) * PROD_W'(recip);
      prod_path_r <= PROD_W'(sum_path) * PROD_W'(recip);
      prod_fill_r <= PROD_W'(sum_fill) * PROD_W'(recip);
    end
    if (adv3 && s2_vld_r) begin
      s3_eor_r   <= s2_eor_r;
      s3_bgnz_r  <= (bg_avg != '0);
      s3_alpha_r <= a_prod[2*LEVEL_W-1:LEVEL_W];
      for (int c = 0; c < 4; c++) begin
        s3_e_r[c] <= e_prod[c][2*LEVEL_W-1:LEVEL_W];
        s3_f_r[c] <= f_prod[c][2*LEVEL_W-1:LEVEL_W];
      end
    end
    if (adv_out && s3_vld_r) begin
      out_data_r <= pixel_nxt;
      out_last_r <= s3_eor_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/core/supersample_outline_colorizer.sv */
// Top level of the supersample outline colorizer.
// Takes one supersample per beat and, for every q-by-q block, delivers one ARGB
// pixel; throughput is one sample per clock unless stalled, set by the
// read-modify-write of the column sum memory (one read and one write port,
// same-column back-to-back beats are forwarded). The input stalls only while
// the output register and both shading stages hold pixels and the block-closing
// sample cannot hand off. After reset the block zeroes all MAX_OUT_WIDTH columns
// of the sum memory (256 by default), one column per cycle, taking no samples
// meanwhile; configuration writes are taken as usual. Registers sit at byte
// addresses 0x0 factor, 0x4 width, 0x8 edge color, 0xC fill color; the user
// must write them only while the block is idle; the block does not enforce it.
`include "supersample_outline_colorizer_defines.svh"

module supersample_outline_colorizer
  import ssoc_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
  parameter int MAX_FACTOR    = DEF_MAX_FACTOR
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // bg_level, path_level, fill_level
  input  logic                  in_tuser,   // start_of_image
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [COLOR_W-1:0]    out_tdata,  // pixel_argb
  output logic                  out_tlast   // end_of_row
);

  localparam int SUM_W = LEVEL_W + $clog2(MAX_FACTOR * MAX_FACTOR);

  cfg_regs_t          cfg;
  blk_tag_t           blk_tag;
  logic [SUM_W-1:0]   sum_bg, sum_path, sum_fill;
  logic               blk_rdy;
  logic               clearing;

  ssoc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ssoc_accum #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_FACTOR    (MAX_FACTOR)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .blk_tag   (blk_tag),
    .sum_bg    (sum_bg),
    .sum_path  (sum_path),
    .sum_fill  (sum_fill),
    .blk_rdy   (blk_rdy),
    .clearing  (clearing)
  );

  ssoc_shade #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_shade (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .blk_tag    (blk_tag),
    .sum_bg     (sum_bg),
    .sum_path   (sum_path),
    .sum_fill   (sum_fill),
    .blk_rdy    (blk_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `SSOC_ASSERT_IMP(a_clear_blocks_input, clearing, !in_tready, "sample taken during sum clear")
  `SSOC_ASSERT_IMP(a_clear_no_pixel, clearing, !out_tvalid, "pixel shown during sum clear")
  `SSOC_ASSERT_NXT(a_blk_hold, blk_tag.vld && !blk_rdy, blk_tag.vld && $stable(blk_tag.eor) && $stable(sum_bg) && $stable(sum_path) && $stable(sum_fill), "stalled block sums changed")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the supersample outline colorizer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ssoc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 400;
  localparam int PIXEL_TARGET   = 48;
  localparam int DRAIN_TAIL     = 8;
  localparam int SHOWN_ERRORS   = 10;

  typedef struct {
    logic [LEVEL_W-1:0] bg;
    logic [LEVEL_W-1:0] path;
    logic [LEVEL_W-1:0] fill;
    logic               soi;
  } sample_t;

  typedef struct {
    logic [COLOR_W-1:0] argb;
    logic               eor;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // bg_level, path_level, fill_level
  logic                  in_tuser = 1'b0; // start_of_image
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [COLOR_W-1:0]    out_tdata;       // pixel_argb
  logic                  out_tlast;       // end_of_row

  supersample_outline_colorizer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the registers and of the block's accumulator state.
  logic [FACTOR_W-1:0] shadow_factor = RST_FACTOR;
  logic [WIDTH_W-1:0]  shadow_width  = RST_WIDTH;
  logic [COLOR_W-1:0]  shadow_edge   = '0;
  logic [COLOR_W-1:0]  shadow_fill   = '0;
  int unsigned         bg_acc   [DEF_MAX_OUT_WIDTH];
  int unsigned         path_acc [DEF_MAX_OUT_WIDTH];
  int unsigned         fill_acc [DEF_MAX_OUT_WIDTH];
  int unsigned         sub_col_pos = 0;
  int unsigned         sub_row_pos = 0;
  int unsigned         col_pos     = 0;

  sample_t     sample_q[$];
  pixel_t      pixel_q[$];
  int          items_total = 0;
  int          pixels_seen = 0;
  int          errors = 0;
  int          idle_pct = 0;
  int          quiet_cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;

  function automatic void note_mismatch(string what);
    errors++;
    if (errors <= SHOWN_ERRORS) $display("MISMATCH: %s", what);
  endfunction

  function automatic int unsigned sat_level(int unsigned v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

  function automatic logic [7:0] blend_channel(logic [7:0] e, logic [7:0] f,
                                               int unsigned pa, int unsigned fa);
    int unsigned mix;
    mix = ((int'(e) * pa) >> 8) + ((int'(f) * fa) >> 8);
    return 8'(sat_level(mix));
  endfunction

  function automatic int unsigned eff_factor(logic [FACTOR_W-1:0] f);
    if (f < 1) return 1;
    if (f > DEF_MAX_FACTOR) return DEF_MAX_FACTOR;
    return f;
  endfunction

  function automatic int unsigned eff_width(logic [WIDTH_W-1:0] w);
    if (w < 1) return 1;
    if (w > DEF_MAX_OUT_WIDTH) return DEF_MAX_OUT_WIDTH;
    return w;
  endfunction

  // Fold one accepted sample into the column sums; queue the pixel it closes.
  function automatic void accumulate_sample(sample_t s);
    int unsigned q, w, col, q2, bg_avg, path_avg, fill_avg, alpha;
    bit last_sc, last_r, last_c;
    pixel_t px;
    q = eff_factor(shadow_factor);
    w = eff_width(shadow_width);
    if (s.soi) begin
      sub_col_pos = 0;
      sub_row_pos = 0;
      col_pos = 0;
    end
    col = col_pos % DEF_MAX_OUT_WIDTH;
    if (sub_row_pos == 0 && sub_col_pos == 0) begin
      bg_acc[col]   = s.bg;
      path_acc[col] = s.path;
      fill_acc[col] = s.fill;
    end else begin
      bg_acc[col]   += s.bg;
      path_acc[col] += s.path;
      fill_acc[col] += s.fill;
    end
    last_sc = (sub_col_pos + 1 >= q);
    last_r  = (sub_row_pos + 1 >= q);
    last_c  = (col_pos + 1 >= w);
    if (!last_sc) begin
      sub_col_pos++;
    end else begin
      sub_col_pos = 0;
      if (last_r) begin
        q2 = q * q;
        bg_avg   = sat_level(bg_acc[col] / q2);
        path_avg = sat_level(path_acc[col] / q2);
        fill_avg = sat_level(fill_acc[col] / q2);
        if (bg_avg != 0) begin
          alpha = ((LEVEL_MAX - bg_avg) * shadow_edge[31:24]) >> 8;
          px.argb = {alpha[7:0], shadow_edge[23:0]};
        end else begin
          px.argb = {blend_channel(shadow_edge[31:24], shadow_fill[31:24], path_avg, fill_avg),
                     blend_channel(shadow_edge[23:16], shadow_fill[23:16], path_avg, fill_avg),
                     blend_channel(shadow_edge[15:8],  shadow_fill[15:8],  path_avg, fill_avg),
                     blend_channel(shadow_edge[7:0],   shadow_fill[7:0],   path_avg, fill_avg)};
        end
        px.eor = last_c;
        pixel_q.push_back(px);
      end
      if (last_c) begin
        col_pos = 0;
        sub_row_pos = last_r ? 0 : sub_row_pos + 1;
      end else begin
        col_pos++;
      end
    end
  endfunction

  // Sample driver: predict on each accepted beat, then present the next one.
  always @(posedge clk) begin : sample_driver
    sample_t seen;
    sample_t nxt;
    bit fire;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        seen.bg   = in_tdata[7:0];
        seen.path = in_tdata[15:8];
        seen.fill = in_tdata[23:16];
        seen.soi  = in_tuser;
        accumulate_sample(seen);
      end
      if (fire || !in_tvalid) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (sample_q.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          in_gap = $urandom_range(1, 14) - 1;
          in_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          nxt = sample_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {nxt.fill, nxt.path, nxt.bg};
          in_tuser  <= nxt.soi;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor with random backpressure.
  always @(posedge clk) begin : pixel_monitor
    pixel_t want;
    bit rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          note_mismatch($sformatf("unexpected pixel argb=%08h eor=%0b", out_tdata, out_tlast));
        end else begin
          want = pixel_q.pop_front();
          if (out_tdata !== want.argb)
            note_mismatch($sformatf("pixel %0d argb expected %08h got %08h",
                                    pixels_seen, want.argb, out_tdata));
          if (out_tlast !== want.eor)
            note_mismatch($sformatf("pixel %0d end_of_row expected %0b got %0b",
                                    pixels_seen, want.eor, out_tlast));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_stall = $urandom_range(1, 14) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_FACTOR: shadow_factor = value[FACTOR_W-1:0];
      REG_WIDTH:  shadow_width  = value[WIDTH_W-1:0];
      REG_EDGE:   shadow_edge   = value;
      REG_FILL:   shadow_fill   = value;
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned f, int unsigned w, logic [31:0] e, logic [31:0] fl);
    write_reg(REG_FACTOR, f);
    write_reg(REG_WIDTH, w);
    write_reg(REG_EDGE, e);
    write_reg(REG_FILL, fl);
    @(negedge clk);
  endtask

  function automatic void queue_sample(int unsigned bg, int unsigned path, int unsigned fill,
                                       bit soi);
    sample_t s;
    s.bg = bg[7:0];
    s.path = path[7:0];
    s.fill = fill[7:0];
    s.soi = soi;
    sample_q.push_back(s);
    items_total++;
  endfunction

  // Hold the sender until every queued pixel has come, then let the pipe settle.
  task automatic wait_for_drain();
    do @(negedge clk); while (sample_q.size() != 0 || in_tvalid || pixel_q.size() != 0);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_color();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random_phase(int idx, bit calm);
    int unsigned f, w, qe, we, images, rows, count, bg_mode, bg;
    bit lead_soi;
    case (idx)
      0: begin f = 15; w = 1; end
      1: begin f = 1; w = 511; end
      2: begin f = 2; w = 256; end
      default: begin
        if ($urandom_range(0, 3) != 0) f = $urandom_range(1, 3);
        else f = $urandom_range(0, 15);
        if (eff_factor(f) == 1 && $urandom_range(0, 9) == 0) w = $urandom_range(0, 511);
        else if (eff_factor(f) <= 2) w = $urandom_range(0, 12);
        else w = $urandom_range(0, 3);
      end
    endcase
    qe = eff_factor(f);
    we = eff_width(w);
    configure(f, w, pick_color(), pick_color());
    case ($urandom_range(0, 3))
      0: idle_pct = 0;
      1: idle_pct = 5;
      2: idle_pct = 20;
      default: idle_pct = 40;
    endcase
    if (calm) idle_pct = 0;
    // Keep the large fixed shapes to one image so the item count stays near target.
    images = (idx < 2) ? 1 : $urandom_range(1, 2);
    for (int img = 0; img < images; img++) begin
      rows = (qe * qe * we > 64) ? 1 : $urandom_range(1, 3);
      count = rows * qe * qe * we;
      if (idx == 2) count = 40;
      else if ($urandom_range(0, 6) == 0) count = $urandom_range(1, count);
      lead_soi = !(img == 0 && $urandom_range(0, 9) == 0);
      case ($urandom_range(0, 4))
        0, 1: bg_mode = 0;
        2: bg_mode = 1;
        default: bg_mode = 2;
      endcase
      for (int n = 0; n < count; n++) begin
        case (bg_mode)
          0: bg = 0;
          1: bg = $urandom_range(0, 1);
          default: bg = $urandom_range(0, 255);
        endcase
        queue_sample(bg, $urandom_range(0, 255), $urandom_range(0, 255),
                     (n == 0 && lead_soi) || ($urandom_range(0, 99) == 0));
      end
    end
    wait_for_drain();
  endtask

  initial begin : stimulus
    int phase_idx;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single-sample blocks: saturation, full and partial background, restart mid-row.
    idle_pct = 20;
    configure(1, 4, 32'hffff_ffff, 32'hffff_ffff);
    queue_sample(0, 255, 255, 1);
    queue_sample(255, 0, 0, 0);
    queue_sample(1, 0, 0, 0);
    queue_sample(0, 0, 0, 0);
    queue_sample(0, 128, 0, 0);
    queue_sample(0, 0, 255, 0);
    queue_sample(0, 1, 1, 1);
    queue_sample(0, 255, 0, 0);
    wait_for_drain();

    // Zero factor and zero width both act as one.
    configure(0, 0, 32'h0000_0000, 32'hffff_ffff);
    queue_sample(0, 255, 255, 1);
    queue_sample(255, 255, 255, 0);
    queue_sample(0, 0, 128, 0);
    wait_for_drain();

    // Stop inside a 2x2 block, then drop the factor so the sums overflow the average.
    configure(2, 2, 32'h80c0_4020, 32'h7f3f_1f0f);
    queue_sample(0, 200, 200, 1);
    queue_sample(0, 200, 200, 0);
    queue_sample(0, 200, 200, 0);
    queue_sample(0, 200, 200, 0);
    queue_sample(0, 200, 200, 0);
    wait_for_drain();
    write_reg(REG_FACTOR, 1);
    @(negedge clk);
    queue_sample(0, 200, 200, 0);
    queue_sample(0, 100, 100, 0);
    queue_sample(0, 255, 255, 0);
    wait_for_drain();

    phase_idx = 0;
    while (items_total < ITEM_TARGET || pixels_seen < PIXEL_TARGET) begin
      run_random_phase(phase_idx, 1'b0);
      phase_idx++;
    end
    run_random_phase(phase_idx, 1'b1);

    if (pixel_q.size() != 0)
      note_mismatch($sformatf("%0d expected pixels never arrived", pixel_q.size()));
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
